// ===== rtl/core/root_motion_velocity_integrator_macros.svh =====
// Assertion macros for the root motion velocity integrator checkers.
// Both macros expect signals named clk and rst_n in the using scope.
`ifndef ROOT_MOTION_VELOCITY_INTEGRATOR_MACROS_SVH
`define ROOT_MOTION_VELOCITY_INTEGRATOR_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RMVI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RMVI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rmvi_pkg.sv =====
// Shared types and constants of the root motion velocity integrator.
// Used by the controller, the datapath and the top level; no dependencies.
package rmvi_pkg;

  // Item opcodes carried in the input tuser.
  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_UPDATE  = 3'd1,
    OP_JUMP    = 3'd2,
    OP_ERROR   = 3'd3,
    OP_CONSUME = 3'd4,
    OP_RESET   = 3'd5
  } op_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_HALFLIFE    = 2'd0,
    REG_KEEP_VERT   = 2'd1,
    REG_GAIN        = 2'd2,
    REG_FRAME_COUNT = 2'd3
  } reg_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_CUR,
    S_RD_PREV,
    S_CAP_PREV,
    S_DIV,
    S_MUL,
    S_DRAIN,
    S_ACC,
    S_JCAP,
    S_LOAD,
    S_EXEC,
    S_FINISH
  } state_t;

  // Kinds of product run through the shared multiplier.
  typedef enum logic [2:0] {
    MK_INTERP,
    MK_BLEND,
    MK_SMOOTH,
    MK_TRANS,
    MK_YAW,
    MK_EG,
    MK_EGD
  } mul_kind_t;

  // Number of multiplier issues in one update.
  localparam int MulSteps = 19;

  typedef struct packed {
    logic [15:0] halflife;
    logic        keep_vertical;
    logic [15:0] gain;
    logic [10:0] frame_count;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      take;
    logic      tab_wr;
    logic      rd_prev;
    logic      div_start;
    logic      cap_cur;
    logic      cap_prev;
    logic      adopt;
    logic      cap_jump;
    logic      mul_go;
    mul_kind_t mul_kind;
    logic [1:0] mul_lane;
    logic      acc_upd;
    logic      set_err;
    logic      clr_motion;
    logic      clr_acc;
    logic      finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic ok;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/rmvi_ctrl.sv =====
// Controller state machine of the root motion velocity integrator.
// Depends on rmvi_pkg; drives the datapath only through cmd_t and reads sts_t.
module rmvi_ctrl import rmvi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t     state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic       last_step;

  assign last_step = (step_r == 5'(MulSteps - 1));

  // State and multiplier step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // The step counter runs only while the multiplier sequence is issued.
  always_comb begin
    step_nxt = (state_r == S_MUL) ? step_r + 5'd1 : '0;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (!sts.ok) begin
          state_nxt = S_FINISH;
        end else begin
          case (sts.op)
            OP_LOAD:            state_nxt = S_LOAD;
            OP_UPDATE, OP_JUMP: state_nxt = S_RD_CUR;
            OP_ERROR, OP_RESET: state_nxt = S_EXEC;
            default:            state_nxt = S_FINISH;
          endcase
        end
      end
      S_RD_CUR:   state_nxt = (sts.op == OP_UPDATE) ? S_RD_PREV : S_JCAP;
      S_RD_PREV:  state_nxt = S_CAP_PREV;
      S_CAP_PREV: state_nxt = S_DIV;
      S_DIV: begin
        if (sts.div_done) state_nxt = S_MUL;
      end
      S_MUL: begin
        if (last_step) state_nxt = S_DRAIN;
      end
      S_DRAIN:    state_nxt = S_ACC;
      S_ACC:      state_nxt = S_FINISH;
      S_JCAP:     state_nxt = S_FINISH;
      S_LOAD:     state_nxt = S_FINISH;
      S_EXEC:     state_nxt = S_FINISH;
      S_FINISH: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd       = '0;
    in_tready = (state_r == S_IDLE);
    cmd.take  = in_tvalid && (state_r == S_IDLE);
    case (state_r)
      S_RD_CUR: begin
        cmd.div_start = (sts.op == OP_UPDATE);
      end
      S_RD_PREV: begin
        cmd.rd_prev = 1'b1;
        cmd.cap_cur = 1'b1;
      end
      S_CAP_PREV: begin
        cmd.cap_prev = 1'b1;
        cmd.adopt    = 1'b1;
      end
      S_MUL: begin
        cmd.mul_go = 1'b1;
        // Issue order puts every consumer after the step in which its producer's result is written.
        if (step_r == 5'd0) begin
          cmd.mul_kind = MK_INTERP;
          cmd.mul_lane = 2'd0;
        end else if (step_r < 5'd5) begin
          cmd.mul_kind = MK_BLEND;
          cmd.mul_lane = 2'(step_r - 5'd1);
        end else if (step_r < 5'd9) begin
          cmd.mul_kind = MK_SMOOTH;
          cmd.mul_lane = 2'(step_r - 5'd5);
        end else if (step_r < 5'd12) begin
          cmd.mul_kind = MK_TRANS;
          cmd.mul_lane = 2'(step_r - 5'd9);
        end else if (step_r == 5'd12) begin
          cmd.mul_kind = MK_YAW;
          cmd.mul_lane = 2'd3;
        end else if (step_r < 5'd16) begin
          cmd.mul_kind = MK_EG;
          cmd.mul_lane = 2'(step_r - 5'd13);
        end else begin
          cmd.mul_kind = MK_EGD;
          cmd.mul_lane = 2'(step_r - 5'd16);
        end
      end
      S_ACC:  cmd.acc_upd = 1'b1;
      S_JCAP: cmd.cap_jump = 1'b1;
      S_LOAD: cmd.tab_wr = 1'b1;
      S_EXEC: begin
        cmd.set_err    = (sts.op == OP_ERROR);
        cmd.clr_motion = (sts.op == OP_RESET);
      end
      S_FINISH: begin
        cmd.finish  = sts.out_free;
        cmd.clr_acc = sts.out_free && sts.ok && (sts.op == OP_CONSUME);
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/rmvi_dp.sv =====
// Datapath of the root motion velocity integrator: velocity table, divider,
// shared multiplier, motion state and output register. Depends on rmvi_pkg.
module rmvi_dp import rmvi_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  input  logic [119:0] in_tdata,
  input  logic [2:0]   in_tuser,
  input  cmd_t         cmd,
  output sts_t         sts,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,
  output logic [0:0]   out_tuser
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [16:0] DepthW = 17'(TABLE_DEPTH);

  // 2^(-i/16) in Q1.16 for i = 0 .. 16.
  function automatic logic [16:0] pow2_frac(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55109;
      5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50535;
      5'd7:  v = 17'd48393;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [28:0] v);
    logic signed [15:0] r;
    if (v[28:15] != {14{v[28]}}) r = v[28] ? 16'sh8000 : 16'sh7fff;
    else r = v[15:0];
    return r;
  endfunction

  // Latched input item.
  logic [2:0]          op_r;
  logic [15:0]         dt_r;
  logic signed [10:0]  now_r, before_r;
  logic [16:0]         mix_r;
  logic signed [15:0]  vec_r [3];
  logic signed [15:0]  yaw_in_r;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r     <= in_tuser;
      dt_r     <= in_tdata[15:0];
      now_r    <= in_tdata[26:16];
      before_r <= in_tdata[37:27];
      mix_r    <= in_tdata[54:38];
      vec_r[0] <= in_tdata[70:55];
      vec_r[1] <= in_tdata[86:71];
      vec_r[2] <= in_tdata[102:87];
      yaw_in_r <= in_tdata[118:103];
    end
  end

  // Frame range checks.
  logic [16:0] frame_lim;
  logic        now_ok, before_ok, load_ok, blend, item_ok;

  assign frame_lim = (17'(cfg.frame_count) > DepthW) ? DepthW : 17'(cfg.frame_count);
  assign now_ok    = !now_r[10] && (17'(now_r[9:0]) < frame_lim);
  assign before_ok = !before_r[10] && (17'(before_r[9:0]) < frame_lim);
  assign load_ok   = !now_r[10] && (17'(now_r[9:0]) < DepthW);
  assign blend     = before_ok && !mix_r[16];

  always_comb begin
    case (op_r)
      OP_LOAD:                         item_ok = load_ok;
      OP_UPDATE, OP_JUMP:              item_ok = now_ok;
      OP_ERROR, OP_CONSUME, OP_RESET:  item_ok = 1'b1;
      default:                         item_ok = 1'b0;
    endcase
  end

  // Velocity table: lanes x, y, z, yaw from the low bits up.
  logic [63:0]   tab_mem [TABLE_DEPTH];
  logic [63:0]   rd_data_r;
  logic [AW-1:0] now_idx, before_idx, rd_addr;

  assign now_idx    = AW'(now_r[9:0]);
  assign before_idx = AW'(before_r[9:0]);
  assign rd_addr    = (cmd.rd_prev && blend) ? before_idx : now_idx;

  always_ff @(posedge clk) begin
    if (cmd.tab_wr) tab_mem[now_idx] <= {yaw_in_r, vec_r[2], vec_r[1], vec_r[0]};
    rd_data_r <= tab_mem[rd_addr];
  end

  logic [63:0] cur_r, prev_r, prev_sel;

  always_ff @(posedge clk) begin
    if (cmd.cap_cur)  cur_r  <= rd_data_r;
    if (cmd.cap_prev) prev_r <= rd_data_r;
  end

  // Without blending the previous entry is the current one, so the blend term is zero.
  assign prev_sel = blend ? prev_r : cur_r;

  // Restoring divider: (step_time << 16) / max(halflife, 7), one bit a cycle.
  logic [15:0] hl_eff, rem_r;
  logic [31:0] quo_r;
  logic [5:0]  dcnt_r;
  logic [16:0] trial;
  logic        trial_ge;

  assign hl_eff   = (cfg.halflife < 16'd7) ? 16'd7 : cfg.halflife;
  assign trial    = {rem_r, quo_r[31]};
  assign trial_ge = (trial >= {1'b0, hl_eff});

  always_ff @(posedge clk) begin
    if (!rst_n) dcnt_r <= '0;
    else if (cmd.div_start) dcnt_r <= 6'd32;
    else if (dcnt_r != '0) dcnt_r <= dcnt_r - 6'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo_r <= {dt_r, 16'h0000};
      rem_r <= '0;
    end else if (dcnt_r != '0) begin
      quo_r <= {quo_r[30:0], trial_ge};
      rem_r <= trial_ge ? 16'(trial - {1'b0, hl_eff}) : trial[15:0];
    end
  end

  // Interpolation points of 2^(-frac).
  logic [16:0] t_lo, t_hi, t_diff;

  assign t_lo   = pow2_frac({1'b0, quo_r[15:12]});
  assign t_hi   = pow2_frac(5'({1'b0, quo_r[15:12]}) + 5'd1);
  assign t_diff = t_lo - t_hi;

  // Motion state, lanes 0..2 linear and lane 3 angular.
  logic signed [23:0] smooth_r [4];
  logic signed [15:0] jump_r [4];
  logic               jump_pending_r;
  logic signed [15:0] err_r [3];
  logic signed [31:0] acc_r [3];
  logic signed [31:0] acc_yaw_r;

  // Intermediate terms of one update.
  logic [16:0]        alpha_r;
  logic signed [24:0] target_r [4];
  logic signed [25:0] tr_r [3];
  logic signed [25:0] yaw_r;
  logic signed [32:0] eg_r [3];

  // Shared multiplier operand selection.
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [23:0] aux_nxt, aux_r;
  logic signed [15:0] cur_lane, prev_lane;
  logic signed [16:0] bdiff;
  logic signed [25:0] sdiff;

  assign cur_lane  = cur_r[{cmd.mul_lane, 4'b0000} +: 16];
  assign prev_lane = prev_sel[{cmd.mul_lane, 4'b0000} +: 16];
  assign bdiff     = 17'(cur_lane) - 17'(prev_lane);
  assign sdiff     = 26'(target_r[cmd.mul_lane]) - 26'(smooth_r[cmd.mul_lane]);

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    aux_nxt = '0;
    case (cmd.mul_kind)
      MK_INTERP: begin
        mul_a = 34'(t_diff);
        mul_b = 18'(quo_r[11:0]);
      end
      MK_BLEND: begin
        mul_a   = 34'(bdiff);
        mul_b   = 18'(mix_r[15:0]);
        aux_nxt = 24'(prev_lane);
      end
      MK_SMOOTH: begin
        mul_a   = 34'(sdiff);
        mul_b   = 18'(alpha_r);
        aux_nxt = smooth_r[cmd.mul_lane];
      end
      MK_TRANS, MK_YAW: begin
        mul_a = 34'(smooth_r[cmd.mul_lane]);
        mul_b = 18'(dt_r);
      end
      MK_EG: begin
        mul_a = 34'(err_r[cmd.mul_lane[1:0]]);
        mul_b = 18'(cfg.gain);
      end
      MK_EGD: begin
        mul_a   = 34'(eg_r[cmd.mul_lane[1:0]]);
        mul_b   = 18'(dt_r);
        aux_nxt = 24'(err_r[cmd.mul_lane[1:0]]);
      end
      default: ;
    endcase
  end

  // Product register and the tag of the product it holds.
  logic signed [51:0] prod_r;
  mul_kind_t          kind_r;
  logic [1:0]         lane_r;
  logic               mvld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) mvld_r <= 1'b0;
    else mvld_r <= cmd.mul_go;
  end

  always_ff @(posedge clk) begin
    prod_r <= 52'(mul_a * mul_b);
    kind_r <= cmd.mul_kind;
    lane_r <= cmd.mul_lane;
    aux_r  <= aux_nxt;
  end

  // Terms derived from the registered product.
  logic [16:0]        p_base, p_val;
  logic signed [27:0] corr;

  assign p_base = t_lo - 17'(prod_r >>> 12);
  assign p_val  = (quo_r[31:16] >= 16'd17) ? '0 : (p_base >> quo_r[20:16]);
  assign corr   = 28'(prod_r >>> 24);

  // Intermediate terms written as their products arrive.
  always_ff @(posedge clk) begin
    if (mvld_r) begin
      case (kind_r)
        MK_INTERP: alpha_r <= 17'd65536 - p_val;
        MK_BLEND:  target_r[lane_r] <= (25'(aux_r) <<< 8) + 25'(prod_r >>> 8);
        MK_TRANS: begin
          if (lane_r == 2'd1 && !cfg.keep_vertical) tr_r[lane_r] <= '0;
          else tr_r[lane_r] <= 26'(prod_r >>> 24);
        end
        MK_YAW:    yaw_r <= 26'(prod_r >>> 20);
        MK_EG:     eg_r[lane_r] <= 33'(prod_r);
        MK_EGD:    tr_r[lane_r] <= tr_r[lane_r] + 26'(corr);
        default: ;
      endcase
    end
  end

  // Motion state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) begin
        smooth_r[k] <= '0;
        jump_r[k]   <= '0;
      end
      for (int k = 0; k < 3; k++) begin
        err_r[k] <= '0;
        acc_r[k] <= '0;
      end
      acc_yaw_r      <= '0;
      jump_pending_r <= 1'b0;
    end else begin
      // Frame jump: remember the entry, adopt it at the next update.
      if (cmd.cap_jump) begin
        for (int k = 0; k < 4; k++) jump_r[k] <= rd_data_r[16*k +: 16];
        jump_pending_r <= 1'b1;
      end
      if (cmd.adopt && jump_pending_r) begin
        for (int k = 0; k < 4; k++) smooth_r[k] <= {jump_r[k], 8'h00};
        jump_pending_r <= 1'b0;
      end
      if (mvld_r && kind_r == MK_SMOOTH) begin
        smooth_r[lane_r] <= aux_r + 24'(prod_r >>> 16);
      end
      if (mvld_r && kind_r == MK_EGD) begin
        err_r[lane_r] <= sat16(29'(aux_r) - 29'(corr));
      end
      // Saturating accumulation closes the update.
      if (cmd.acc_upd) begin
        for (int k = 0; k < 3; k++) acc_r[k] <= sat32(33'(acc_r[k]) + 33'(tr_r[k]));
        acc_yaw_r <= sat32(33'(acc_yaw_r) + 33'(yaw_r));
      end
      if (cmd.set_err) begin
        for (int k = 0; k < 3; k++) err_r[k] <= vec_r[k];
      end
      if (cmd.clr_motion) begin
        for (int k = 0; k < 4; k++) smooth_r[k] <= '0;
        for (int k = 0; k < 3; k++) begin
          err_r[k] <= '0;
          acc_r[k] <= '0;
        end
        acc_yaw_r      <= '0;
        jump_pending_r <= 1'b0;
      end
      // Consume clears after the output register has taken the old totals.
      if (cmd.clr_acc) begin
        for (int k = 0; k < 3; k++) acc_r[k] <= '0;
        acc_yaw_r <= '0;
      end
    end
  end

  // Output register: a new result may replace one that is taken in the same cycle.
  logic         out_tvalid_r;
  logic [191:0] out_data_r;
  logic         out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid_r <= 1'b0;
    else if (cmd.finish) out_tvalid_r <= 1'b1;
    else if (out_tready) out_tvalid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_user_r <= item_ok;
      out_data_r <= {acc_yaw_r, acc_r[2], acc_r[1], acc_r[0],
                     smooth_r[3][23:8], smooth_r[2][23:8],
                     smooth_r[1][23:8], smooth_r[0][23:8]};
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_user_r;

  // Status to the controller.
  always_comb begin
    sts.op       = op_t'(op_r);
    sts.ok       = item_ok;
    sts.div_done = (dcnt_r == '0);
    sts.out_free = !out_tvalid_r || out_tready;
  end

endmodule

// ===== rtl/core/root_motion_velocity_integrator.sv =====
// Top level of the root motion velocity integrator: configuration registers
// and the APB-style port, joining rmvi_ctrl and rmvi_dp. Depends on rmvi_pkg.
//
// One item is taken at a time and gives exactly one result. After the decode
// state, a table load passes through the load state, a frame jump through the
// table read and the jump capture, error and reset through the execute state,
// and consume and any rejected item go straight to the finish state. An update
// reads the current and the previous entry, runs the 32-step restoring divider
// that forms step_time / halflife, then passes 19 products one per cycle
// through a single 34 x 18 multiplier before the accumulation. The next item is
// taken in the cycle after a result is written to the output register, even if
// that result is still waiting to be transferred. The velocity table has no
// clearing pass and must be loaded before an entry is used.
module root_motion_velocity_integrator import rmvi_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // step_time[15:0], frame_now[26:16], frame_before[37:27], mix[54:38],
  // vec_x[70:55], vec_y[86:71], vec_z[102:87], yaw_rate[118:103], zero pad
  input  logic [119:0] in_tdata,
  // opcode[2:0]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // vel_x[15:0], vel_y[31:16], vel_z[47:32], turn_rate[63:48],
  // moved_x[95:64], moved_y[127:96], moved_z[159:128], turned[191:160]
  output logic [191:0] out_tdata,
  // accepted[0]
  output logic [0:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [15:0] halflife_r;
  logic        keep_vert_r;
  logic [15:0] gain_r;
  logic [10:0] frame_count_r;
  logic        cfg_wr;
  reg_t        cfg_sel;
  cfg_t        cfg;
  cmd_t        cmd;
  sts_t        sts;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = reg_t'(cfg_paddr[3:2]);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halflife_r    <= 16'd6554;
      keep_vert_r   <= 1'b0;
      gain_r        <= '0;
      frame_count_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_HALFLIFE:    halflife_r    <= cfg_pwdata[15:0];
        REG_KEEP_VERT:   keep_vert_r   <= cfg_pwdata[0];
        REG_GAIN:        gain_r        <= cfg_pwdata[15:0];
        REG_FRAME_COUNT: frame_count_r <= cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Configuration read-back.
  always_comb begin
    case (cfg_sel)
      REG_HALFLIFE:    cfg_prdata = {16'h0000, halflife_r};
      REG_KEEP_VERT:   cfg_prdata = {31'h0, keep_vert_r};
      REG_GAIN:        cfg_prdata = {16'h0000, gain_r};
      REG_FRAME_COUNT: cfg_prdata = {21'h0, frame_count_r};
      default:         cfg_prdata = '0;
    endcase
  end

  always_comb begin
    cfg.halflife      = halflife_r;
    cfg.keep_vertical = keep_vert_r;
    cfg.gain          = gain_r;
    cfg.frame_count   = frame_count_r;
  end

  rmvi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rmvi_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== rtl/core/rmvi_chk.sv =====
// Port-level checker of the root motion velocity integrator, bound to the top.
// Depends on root_motion_velocity_integrator_macros.svh.
`include "root_motion_velocity_integrator_macros.svh"

module rmvi_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [191:0] out_tdata,
  input logic [0:0]   out_tuser
);

  // A stalled result holds.
  `RMVI_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // Only one item is in work at a time.
  `RMVI_ASSERT_NXT(a_one_item, in_tvalid && in_tready, !in_tready,
    "input ready right after a transfer")

  // A new result appears only when the block has turned idle.
  `RMVI_ASSERT_IMP(a_result_idle, $rose(out_tvalid), in_tready,
    "result written while an item is still in work")

endmodule

bind root_motion_velocity_integrator rmvi_chk u_chk (.*);

// ===== test/tb_root_motion_velocity_integrator.sv =====
// Testbench of root_motion_velocity_integrator: a directed table, then random
// phases under several register settings, checked by an in-bench predictor.
// Depends on rmvi_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_root_motion_velocity_integrator;
  import rmvi_pkg::*;

  localparam int Depth      = 1024;
  localparam int CycleLimit = 600000;
  localparam int DrainWait  = 80;

  typedef struct {
    logic [2:0] op;
    int dt, now, bef, mix, vx, vy, vz, yaw;
  } item_t;

  typedef struct {
    bit    is_cfg;
    reg_t  rg;
    int    val;
    item_t it;
    bit    typed;
    bit    tacc;
  } row_t;

  logic         clk;
  logic         rst_n       = 1'b0;
  logic         in_tvalid   = 1'b0;
  logic         in_tready;
  logic [119:0] in_tdata    = '0;
  logic [2:0]   in_tuser    = '0;
  logic         out_tvalid;
  logic         out_tready  = 1'b0;
  logic [191:0] out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_psel    = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite  = 1'b0;
  logic [3:0]   cfg_paddr   = '0;
  logic [31:0]  cfg_pwdata  = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  root_motion_velocity_integrator i_dut (.*);

  // Predictor state: lanes 0..2 are linear x, y, z and lane 3 is the yaw.
  longint vel_table [Depth][4];
  bit     table_written [Depth];
  int     written_idx_q [$];
  longint smooth_vel [4];
  longint jump_vel [4];
  bit     jump_armed;
  longint pos_error [3];
  longint moved_acc [4];
  longint halflife_reg, keep_vert_reg, gain_reg, frame_count_reg;

  longint two_pow_frac [17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                                 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219,
                                 32768};
  string  field_name [9] = '{"vel_x", "vel_y", "vel_z", "turn_rate", "moved_x",
                             "moved_y", "moved_z", "turned", "accepted"};

  logic [192:0] expected_motion_q [$];
  int           errors = 0;
  int           cycles = 0;
  bit           idle_on = 1'b1;
  bit           hold_req = 1'b0;

  function automatic longint saturate(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic bit frame_valid(int f);
    longint n;
    n = (frame_count_reg > Depth) ? Depth : frame_count_reg;
    return f >= 0 && f < n;
  endfunction

  // Expected result {accepted, tdata} of one item; advances the predictor state.
  function automatic logic [192:0] predict_motion(item_t it);
    logic [192:0] res;
    longint shown [4];
    longint tr [4];
    longint h, e, ip, fr, i, pw, alpha, t, corr;
    bit     acc, blend;
    int     src;
    acc = 1'b1;
    for (int k = 0; k < 4; k++) shown[k] = moved_acc[k];
    case (op_t'(it.op))
      OP_LOAD: begin
        if (it.now >= 0 && it.now < Depth) begin
          vel_table[it.now][0] = it.vx;
          vel_table[it.now][1] = it.vy;
          vel_table[it.now][2] = it.vz;
          vel_table[it.now][3] = it.yaw;
        end else begin
          acc = 1'b0;
        end
      end
      OP_UPDATE: begin
        if (frame_valid(it.now)) begin
          blend = frame_valid(it.bef) && it.mix < 65536;
          src = blend ? it.bef : it.now;
          // Smoothing factor alpha = 1 - 2^(-dt/halflife).
          h = (halflife_reg < 7) ? 7 : halflife_reg;
          e = (longint'(it.dt) <<< 16) / h;
          ip = e >>> 16;
          fr = e & 65535;
          i = fr >>> 12;
          pw = two_pow_frac[i] -
               (((two_pow_frac[i] - two_pow_frac[i + 1]) * (fr & 4095)) >>> 12);
          pw = (ip >= 17) ? 0 : (pw >>> ip);
          alpha = 65536 - pw;
          if (jump_armed) begin
            for (int k = 0; k < 4; k++) smooth_vel[k] = jump_vel[k] * 256;
            jump_armed = 1'b0;
          end
          for (int k = 0; k < 4; k++) begin
            if (blend)
              t = vel_table[src][k] * 256 +
                  (((vel_table[it.now][k] - vel_table[src][k]) * it.mix) >>> 8);
            else
              t = vel_table[it.now][k] * 256;
            smooth_vel[k] += ((t - smooth_vel[k]) * alpha) >>> 16;
            tr[k] = (smooth_vel[k] * it.dt) >>> ((k == 3) ? 20 : 24);
          end
          if (keep_vert_reg == 0) tr[1] = 0;
          // Position error feedback.
          if (gain_reg != 0 && (pos_error[0] | pos_error[1] | pos_error[2]) != 0) begin
            for (int k = 0; k < 3; k++) begin
              corr = (pos_error[k] * gain_reg * it.dt) >>> 24;
              tr[k] += corr;
              pos_error[k] = saturate(pos_error[k] - corr, 16);
            end
          end
          for (int k = 0; k < 4; k++) moved_acc[k] = saturate(moved_acc[k] + tr[k], 32);
        end else begin
          acc = 1'b0;
        end
      end
      OP_JUMP: begin
        if (frame_valid(it.now)) begin
          for (int k = 0; k < 4; k++) jump_vel[k] = vel_table[it.now][k];
          jump_armed = 1'b1;
        end else begin
          acc = 1'b0;
        end
      end
      OP_ERROR: begin
        pos_error[0] = it.vx;
        pos_error[1] = it.vy;
        pos_error[2] = it.vz;
      end
      OP_CONSUME: begin
        for (int k = 0; k < 4; k++) moved_acc[k] = 0;
      end
      OP_RESET: begin
        for (int k = 0; k < 4; k++) begin
          smooth_vel[k] = 0;
          moved_acc[k] = 0;
        end
        for (int k = 0; k < 3; k++) pos_error[k] = 0;
        jump_armed = 1'b0;
      end
      default: acc = 1'b0;
    endcase
    if (op_t'(it.op) != OP_CONSUME)
      for (int k = 0; k < 4; k++) shown[k] = moved_acc[k];
    res[192] = acc;
    for (int k = 0; k < 4; k++) begin
      res[16 * k +: 16]      = 16'(smooth_vel[k] >>> 8);
      res[64 + 32 * k +: 32] = 32'(shown[k]);
    end
    return res;
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_root_motion_velocity_integrator: errors");
      $finish;
    end
  end

  // Receiver side: random stalls, and one long hold-off on request.
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Result checking against the oldest expectation.
  always @(posedge clk) begin
    logic [192:0] exp_res, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata};
      if (expected_motion_q.size() == 0) begin
        $display("%0t: unexpected result transfer, got %h", $time, got);
        errors++;
      end else begin
        exp_res = expected_motion_q.pop_front();
        for (int k = 0; k < 9; k++) begin
          if (k < 4 && exp_res[16 * k +: 16] !== got[16 * k +: 16]) begin
            $display("%0t: %s expected %h got %h", $time, field_name[k],
                     exp_res[16 * k +: 16], got[16 * k +: 16]);
            errors++;
          end else if (k >= 4 && k < 8 &&
                       exp_res[64 + 32 * (k - 4) +: 32] !== got[64 + 32 * (k - 4) +: 32]) begin
            $display("%0t: %s expected %h got %h", $time, field_name[k],
                     exp_res[64 + 32 * (k - 4) +: 32], got[64 + 32 * (k - 4) +: 32]);
            errors++;
          end else if (k == 8 && exp_res[192] !== got[192]) begin
            $display("%0t: %s expected %b got %b", $time, field_name[k],
                     exp_res[192], got[192]);
            errors++;
          end
        end
      end
    end
  end

  // Offers one item, waits for its transfer, then records the expectation.
  task automatic send_item(item_t it, bit typed, bit tacc);
    logic [192:0] pred;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= {1'b0, 16'(it.yaw), 16'(it.vz), 16'(it.vy), 16'(it.vx), 17'(it.mix),
                  11'(it.bef), 11'(it.now), 16'(it.dt)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = predict_motion(it);
    if (op_t'(it.op) == OP_LOAD && it.now >= 0 && it.now < Depth && !table_written[it.now]) begin
      table_written[it.now] = 1'b1;
      written_idx_q.push_back(it.now);
    end
    expected_motion_q.push_back(typed ? {tacc, 192'b0} : pred);
  endtask

  // Holds the input until every expected result has arrived, then lets the block settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_motion_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_reg(reg_t rg, int val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {rg, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (rg)
      REG_HALFLIFE:    halflife_reg    = val & 16'hFFFF;
      REG_KEEP_VERT:   keep_vert_reg   = val & 1;
      REG_GAIN:        gain_reg        = val & 16'hFFFF;
      REG_FRAME_COUNT: frame_count_reg = val & 11'h7FF;
      default: ;
    endcase
  endtask

  function automatic item_t mk(logic [2:0] op, int dt, int now, int bef, int mix,
                               int vx, int vy, int vz, int yaw);
    item_t it;
    it.op = op; it.dt = dt; it.now = now; it.bef = bef; it.mix = mix;
    it.vx = vx; it.vy = vy; it.vz = vz; it.yaw = yaw;
    return it;
  endfunction

  function automatic row_t item_row(item_t it, bit typed = 1'b0, bit tacc = 1'b0);
    row_t r;
    r.is_cfg = 1'b0; r.rg = REG_HALFLIFE; r.val = 0;
    r.it = it; r.typed = typed; r.tacc = tacc;
    return r;
  endfunction

  function automatic row_t cfg_row(reg_t rg, int val);
    row_t r;
    r = item_row(mk(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0));
    r.is_cfg = 1'b1; r.rg = rg; r.val = val;
    return r;
  endfunction

  // A written frame inside the current frame count.
  function automatic int pick_frame();
    int f;
    do f = written_idx_q[$urandom_range(0, written_idx_q.size() - 1)];
    while (!frame_valid(f));
    return f;
  endfunction

  // A frame index the block must ignore.
  function automatic int bad_frame();
    if (frame_count_reg < Depth && $urandom_range(0, 1) == 0)
      return $urandom_range(frame_count_reg, Depth - 1);
    return -int'($urandom_range(1, Depth));
  endfunction

  function automatic item_t random_item();
    item_t it;
    int r;
    r = $urandom_range(0, 99);
    it = mk(OP_UPDATE, $urandom_range(0, 65535), 0, 0, $urandom_range(0, 65536),
            $signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)),
            $signed(16'($urandom)));
    if ($urandom_range(0, 2) == 0) it.mix = 65536;
    it.bef = ($urandom_range(0, 9) < 6) ? pick_frame() : bad_frame();
    if (r < 55) begin
      it.now = ($urandom_range(0, 11) == 0) ? bad_frame() : pick_frame();
    end else if (r < 65) begin
      it.op  = OP_LOAD;
      it.now = ($urandom_range(0, 19) == 0) ? -int'($urandom_range(1, Depth))
                                             : $urandom_range(0, Depth - 1);
    end else if (r < 75) begin
      it.op  = OP_JUMP;
      it.now = ($urandom_range(0, 5) == 0) ? bad_frame() : pick_frame();
    end else begin
      it.now = bad_frame();
      if (r < 85) begin
        it.op = OP_ERROR;
        if ($urandom_range(0, 4) == 0) begin
          it.vx = 0; it.vy = 0; it.vz = 0;
        end
      end else begin
        it.op = (r < 93) ? OP_CONSUME : OP_RESET;
      end
    end
    return it;
  endfunction

  initial begin
    row_t   dir_tbl [$];
    int     phase_cfg [5][4];
    int     n_load;
    phase_cfg = '{'{6554, 0, 0, 8}, '{7, 1, 65535, 16}, '{65535, 1, 200, 1024},
                  '{0, 0, 0, 0}, '{3000, 1, 1000, 12}};
    phase_cfg[3] = '{$urandom_range(7, 65535), $urandom_range(0, 1),
                     $urandom_range(0, 65535), $urandom_range(1, 40)};
    halflife_reg = 6554; keep_vert_reg = 0; gain_reg = 0; frame_count_reg = 0;
    jump_armed = 1'b0;
    for (int k = 0; k < 4; k++) begin
      smooth_vel[k] = 0; jump_vel[k] = 0; moved_acc[k] = 0;
    end
    for (int k = 0; k < 3; k++) pos_error[k] = 0;

    // Directed part: empty table and ignored items first, then the edges.
    dir_tbl.push_back(item_row(mk(OP_UPDATE, 100, 0, -1, 65536, 0, 0, 0, 0), 1, 0));
    dir_tbl.push_back(item_row(mk(OP_JUMP, 0, 0, -1, 0, 0, 0, 0, 0), 1, 0));
    dir_tbl.push_back(item_row(mk(OP_LOAD, 0, -1, 0, 0, 5, 5, 5, 5), 1, 0));
    dir_tbl.push_back(item_row(mk(OP_LOAD, 0, 1023, 0, 0, 32767, -32768, 1, -1), 1, 1));
    dir_tbl.push_back(item_row(mk(OP_ERROR, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1));
    dir_tbl.push_back(item_row(mk(OP_CONSUME, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1));
    dir_tbl.push_back(item_row(mk(OP_RESET, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1));
    dir_tbl.push_back(item_row(mk(OP_LOAD, 0, 0, 0, 0, 32767, 32767, 32767, 32767)));
    dir_tbl.push_back(item_row(mk(OP_LOAD, 0, 1, 0, 0, -32768, -32768, -32768, -32768)));
    dir_tbl.push_back(item_row(mk(OP_LOAD, 0, 2, 0, 0, 256, -512, 1000, 4096)));
    dir_tbl.push_back(cfg_row(REG_FRAME_COUNT, 3));
    dir_tbl.push_back(cfg_row(REG_KEEP_VERT, 1));
    dir_tbl.push_back(cfg_row(REG_GAIN, 256));
    dir_tbl.push_back(cfg_row(REG_HALFLIFE, 7));
    dir_tbl.push_back(item_row(mk(OP_UPDATE, 65535, 0, -1, 65536, 0, 0, 0, 0)));
    dir_tbl.push_back(item_row(mk(OP_UPDATE, 1000, 1, 0, 0, 0, 0, 0, 0)));
    dir_tbl.push_back(item_row(mk(OP_UPDATE, 6554, 2, 1, 32768, 0, 0, 0, 0)));
    dir_tbl.push_back(item_row(mk(OP_UPDATE, 300, 2, 1023, 65535, 0, 0, 0, 0)));
    dir_tbl.push_back(item_row(mk(OP_UPDATE, 300, 3, 0, 0, 0, 0, 0, 0)));
    dir_tbl.push_back(item_row(mk(OP_JUMP, 0, 1, 0, 0, 0, 0, 0, 0)));
    dir_tbl.push_back(item_row(mk(OP_ERROR, 0, 0, 0, 0, 32767, -32768, 100, 0)));
    dir_tbl.push_back(item_row(mk(OP_UPDATE, 0, 0, 2, 1, 0, 0, 0, 0)));
    dir_tbl.push_back(item_row(mk(OP_UPDATE, 500, 2, -1, 65536, 0, 0, 0, 0)));
    dir_tbl.push_back(item_row(mk(OP_CONSUME, 0, 0, 0, 0, 0, 0, 0, 0)));
    dir_tbl.push_back(cfg_row(REG_HALFLIFE, 65535));
    dir_tbl.push_back(cfg_row(REG_GAIN, 65535));
    dir_tbl.push_back(cfg_row(REG_KEEP_VERT, 0));
    dir_tbl.push_back(item_row(mk(OP_UPDATE, 65535, 1, -1, 65536, 0, 0, 0, 0)));
    dir_tbl.push_back(item_row(mk(OP_RESET, 0, 0, 0, 0, 0, 0, 0, 0)));
    dir_tbl.push_back(item_row(mk(OP_JUMP, 0, -1, 0, 0, 0, 0, 0, 0)));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[r]) begin
      if (dir_tbl[r].is_cfg) begin
        drain();
        write_reg(dir_tbl[r].rg, dir_tbl[r].val);
      end else begin
        send_item(dir_tbl[r].it, dir_tbl[r].typed, dir_tbl[r].tacc);
      end
    end

    // Random phases, each under its own register setting.
    for (int p = 0; p < 5; p++) begin
      drain();
      write_reg(REG_HALFLIFE, phase_cfg[p][0]);
      write_reg(REG_KEEP_VERT, phase_cfg[p][1]);
      write_reg(REG_GAIN, phase_cfg[p][2]);
      write_reg(REG_FRAME_COUNT, phase_cfg[p][3]);
      if (p == 4) idle_on = 1'b0;
      n_load = (phase_cfg[p][3] < 16) ? phase_cfg[p][3] : 16;
      for (int f = 0; f < n_load; f++)
        send_item(mk(OP_LOAD, $urandom_range(0, 65535), f, -1, 0,
                     $signed(16'($urandom)), $signed(16'($urandom)),
                     $signed(16'($urandom)), $signed(16'($urandom))), 0, 0);
      if (p == 1) hold_req = 1'b1;
      for (int n = 0; n < 100; n++) send_item(random_item(), 0, 0);
    end

    drain();
    if (errors == 0)
      $display("tb_root_motion_velocity_integrator: clean");
    else
      $display("tb_root_motion_velocity_integrator: errors");
    $finish;
  end

endmodule
